[hdl/rwcp_pkg.sv]
// Shared types and constants for the RIFF/WAVE chunk parser.
`default_nettype none
package rwcp_pkg;

  // Four-character codes as read little-endian from the file
  localparam logic [31:0] FOURCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FOURCC_WAVE = 32'h4556_4157;
  localparam logic [31:0] FOURCC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] FOURCC_DATA = 32'h6174_6164;

  // Result kinds
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_FAIL   = 2'd2;

  typedef enum logic [6:0] {
    PH_RIFF_ID   = 7'b0000001,
    PH_RIFF_SIZE = 7'b0000010,
    PH_WAVE_TYPE = 7'b0000100,
    PH_CHUNK_ID  = 7'b0001000,
    PH_CHUNK_LEN = 7'b0010000,
    PH_PAYLOAD   = 7'b0100000,
    PH_IDLE      = 7'b1000000
  } phase_t;

  // Everything one file byte produces: an optional format byte, then an
  // optional end result (success or failure).
  typedef struct packed {
    logic        has_fmt;
    logic [7:0]  fmt_byte;
    logic        has_end;
    logic        end_ok;
    logic [31:0] offset;
    logic [31:0] length;
  } entry_t;

endpackage
`default_nettype wire

[hdl/rwcp_front.sv]
// Front end: walks header and chunks one byte at a time and classifies results.
`default_nettype none
module rwcp_front
  import rwcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] file_byte,
  input  wire logic       end_of_file,
  output logic            push,
  output entry_t          ent
);

  phase_t      phase, phase_next;
  logic [31:0] field_shift, field_shift_next;
  logic [1:0]  field_byte_count, field_byte_count_next;
  logic [31:0] chunk_id, chunk_id_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] file_position, file_position_next;
  logic        format_seen, format_seen_next;
  logic        audio_seen, audio_seen_next;
  logic [31:0] saved_offset, saved_offset_next;
  logic [31:0] saved_length, saved_length_next;

  logic [31:0] shift_new;
  logic        word_done;
  logic [31:0] pos_inc;
  logic [31:0] rem_dec;
  logic        data_first;
  logic        emit;

  always_comb begin
    phase_next             = phase;
    field_shift_next       = field_shift;
    field_byte_count_next  = field_byte_count;
    chunk_id_next          = chunk_id;
    payload_remaining_next = payload_remaining;
    file_position_next     = file_position;
    format_seen_next       = format_seen;
    audio_seen_next        = audio_seen;
    saved_offset_next      = saved_offset;
    saved_length_next      = saved_length;
    ent                    = '0;

    shift_new  = {file_byte, field_shift[31:8]};
    word_done  = (field_byte_count == 2'd3);
    pos_inc    = file_position + 32'd1;
    rem_dec    = payload_remaining - 32'd1;
    data_first = (chunk_id == FOURCC_DATA) && !audio_seen;
    emit       = (chunk_id == FOURCC_FMT) && !format_seen;

    case (phase)
      PH_RIFF_ID: begin
        field_shift_next      = shift_new;
        field_byte_count_next = field_byte_count + 2'd1;
        if (word_done) begin
          if (shift_new != FOURCC_RIFF) begin
            ent.has_end = 1'b1;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = PH_RIFF_SIZE;
          end
        end
      end
      PH_RIFF_SIZE: begin
        field_shift_next      = shift_new;
        field_byte_count_next = field_byte_count + 2'd1;
        if (word_done) phase_next = PH_WAVE_TYPE;
      end
      PH_WAVE_TYPE: begin
        field_shift_next      = shift_new;
        field_byte_count_next = field_byte_count + 2'd1;
        if (word_done) begin
          if (shift_new != FOURCC_WAVE) begin
            ent.has_end = 1'b1;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = PH_CHUNK_ID;
          end
        end
      end
      PH_CHUNK_ID: begin
        field_shift_next      = shift_new;
        field_byte_count_next = field_byte_count + 2'd1;
        if (word_done) begin
          chunk_id_next = shift_new;
          phase_next    = PH_CHUNK_LEN;
        end
      end
      PH_CHUNK_LEN: begin
        field_shift_next      = shift_new;
        field_byte_count_next = field_byte_count + 2'd1;
        if (word_done) begin
          payload_remaining_next = shift_new;
          phase_next = (shift_new == 32'd0) ? PH_CHUNK_ID : PH_PAYLOAD;
          if (data_first) begin
            audio_seen_next   = 1'b1;
            saved_offset_next = pos_inc;
            saved_length_next = shift_new;
          end
          // an empty fmt chunk counts as seen once its length is in
          if (emit && shift_new == 32'd0) format_seen_next = 1'b1;
          if (format_seen_next && audio_seen_next) begin
            ent.has_end = 1'b1;
            ent.end_ok  = 1'b1;
            ent.offset  = saved_offset_next;
            ent.length  = saved_length_next;
            phase_next  = PH_IDLE;
          end
        end
      end
      PH_PAYLOAD: begin
        ent.has_fmt            = emit;
        ent.fmt_byte           = emit ? file_byte : 8'd0;
        payload_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next       = PH_CHUNK_ID;
          format_seen_next = format_seen | emit;
          if (format_seen_next && audio_seen) begin
            ent.has_end = 1'b1;
            ent.end_ok  = 1'b1;
            ent.offset  = saved_offset;
            ent.length  = saved_length;
            phase_next  = PH_IDLE;
          end
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase

    if (phase != PH_IDLE) file_position_next = pos_inc;

    // end of file: fail if still parsing, then start over
    if (end_of_file) begin
      if (phase_next != PH_IDLE) begin
        ent.has_end = 1'b1;
        ent.end_ok  = 1'b0;
        ent.offset  = '0;
        ent.length  = '0;
      end
      phase_next             = PH_RIFF_ID;
      field_shift_next       = '0;
      field_byte_count_next  = '0;
      chunk_id_next          = '0;
      payload_remaining_next = '0;
      file_position_next     = '0;
      format_seen_next       = 1'b0;
      audio_seen_next        = 1'b0;
      saved_offset_next      = '0;
      saved_length_next      = '0;
    end
  end

  assign push = fire && (ent.has_fmt || ent.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_RIFF_ID;
      field_shift       <= '0;
      field_byte_count  <= '0;
      chunk_id          <= '0;
      payload_remaining <= '0;
      file_position     <= '0;
      format_seen       <= 1'b0;
      audio_seen        <= 1'b0;
      saved_offset      <= '0;
      saved_length      <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      field_shift       <= field_shift_next;
      field_byte_count  <= field_byte_count_next;
      chunk_id          <= chunk_id_next;
      payload_remaining <= payload_remaining_next;
      file_position     <= file_position_next;
      format_seen       <= format_seen_next;
      audio_seen        <= audio_seen_next;
      saved_offset      <= saved_offset_next;
      saved_length      <= saved_length_next;
    end
  end

endmodule
`default_nettype wire

[hdl/rwcp_queue.sv]
// Short request queue between the parser front end and the result back end.
`default_nettype none
module rwcp_queue
  import rwcp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_ent,
  input  wire logic   pop,
  output entry_t      head,
  output logic        not_empty,
  output logic        full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/rwcp_back.sv]
// Back end: expands each queued request into one or two result items.
`default_nettype none
module rwcp_back
  import rwcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t head,
  input  wire logic   not_empty,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  format_byte,
  output logic [31:0] audio_offset,
  output logic [31:0] audio_length,
  output logic        last_of_run
);

  // set once the format byte of a two-result request has gone out
  logic step;
  logic show_fmt;
  logic out_fire;

  assign show_fmt  = head.has_fmt && !step;
  assign out_valid = not_empty;
  assign out_fire  = out_valid && !out_stall;

  always_comb begin
    if (show_fmt) begin
      kind         = KIND_FORMAT;
      format_byte  = head.fmt_byte;
      audio_offset = '0;
      audio_length = '0;
      last_of_run  = !head.has_end;
    end else begin
      kind         = head.end_ok ? KIND_DONE : KIND_FAIL;
      format_byte  = '0;
      audio_offset = head.offset;
      audio_length = head.length;
      last_of_run  = 1'b1;
    end
  end

  assign pop = out_fire && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 1'b0;
    end else if (pop) begin
      step <= 1'b0;
    end else if (out_fire) begin
      step <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/riff_wave_chunk_parser_unit.sv]
// RIFF/WAVE chunk parser: byte stream in, format bytes and parse results out.
//
// Input channel: file_byte and end_of_file, one file byte per request, taken
// when in_valid is high and in_stall is low. end_of_file marks the last byte;
// the parser starts over on the next byte.
// Output channel: kind, format_byte, audio_offset, audio_length, last_of_run,
// taken when out_valid is high and out_stall is low. A byte gives zero, one
// or two results; last_of_run flags the final one of each byte.
// Results are registered in the request queue before they are offered.
// Throughput: one byte per cycle while in_stall is low. A byte with two results (last fmt payload
// byte followed by success, or a fmt byte followed by an end-of-file failure)
// holds the output for both of them; the request queue between the parser and
// the result stage absorbs that.
// in_stall rises only when the request queue (QUEUE_DEPTH entries) is full,
// so a stalled output backs up into the input after QUEUE_DEPTH requests
// that carry results; bytes without results never enter the queue.
// Reset empties the queue and returns the parser to the RIFF id.
`default_nettype none
module riff_wave_chunk_parser_unit
  import rwcp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  file_byte,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       format_byte,
  output logic [31:0]      audio_offset,
  output logic [31:0]      audio_length,
  output logic             last_of_run
);

  logic   fire;
  logic   push;
  logic   pop;
  logic   not_empty;
  logic   full;
  entry_t push_ent;
  entry_t head;

  assign in_stall = full;
  assign fire     = in_valid && !in_stall;

  rwcp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .push        (push),
    .ent         (push_ent)
  );

  rwcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  rwcp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .format_byte  (format_byte),
    .audio_offset (audio_offset),
    .audio_length (audio_length),
    .last_of_run  (last_of_run)
  );

  // a format byte that is not last of its run is always followed by its end result
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("second result of a run missing");

  // success and failure always close a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_FORMAT |-> last_of_run)
    else $error("end result not flagged last");

  // nothing is offered right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

[test/tb_riff_wave_chunk_parser_unit.sv]
// Testbench for the RIFF/WAVE chunk parser: random file streams against a built-in parser model.
`timescale 1ns / 1ps
module tb_riff_wave_chunk_parser_unit;
  import rwcp_pkg::*;

  localparam int unsigned BYTE_TARGET = 1550;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    bit         drain;
  } file_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fmt;
    logic [31:0] off;
    logic [31:0] len;
    logic        last;
  } parse_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  file_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  format_byte;
  logic [31:0] audio_offset;
  logic [31:0] audio_length;
  logic        last_of_run;

  file_req_t     byte_requests[$];
  logic [7:0]    file_bytes[$];
  parse_result_t results_due[$];
  parse_result_t step_results[$];

  // Parser model state
  phase_t      ph;
  logic [31:0] shift_word;
  logic [1:0]  word_bytes;
  logic [31:0] cur_id;
  logic [31:0] remaining;
  logic [31:0] position;
  bit          fmt_seen;
  bit          data_seen;
  logic [31:0] data_off;
  logic [31:0] data_len;
  bit          done;

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;

  riff_wave_chunk_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .file_byte    (file_byte),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .format_byte  (format_byte),
    .audio_offset (audio_offset),
    .audio_length (audio_length),
    .last_of_run  (last_of_run)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_parser();
    ph = PH_RIFF_ID;
    shift_word = '0;
    word_bytes = '0;
    cur_id = '0;
    remaining = '0;
    position = '0;
    fmt_seen = 1'b0;
    data_seen = 1'b0;
    data_off = '0;
    data_len = '0;
    done = 1'b0;
  endtask

  function automatic void add_result(logic [1:0] k, logic [7:0] fb, logic [31:0] off,
                                     logic [31:0] len);
    parse_result_t r;
    r = '{k, fb, off, len, 1'b0};
    step_results.push_back(r);
  endfunction

  task automatic give_failure();
    add_result(KIND_FAIL, 8'd0, 32'd0, 32'd0);
    done = 1'b1;
    ph = PH_IDLE;
  endtask

  task automatic check_complete();
    if (fmt_seen && data_seen) begin
      add_result(KIND_DONE, 8'd0, data_off, data_len);
      done = 1'b1;
      ph = PH_IDLE;
    end
  endtask

  // Advance the parser model by one accepted byte and queue what it produces.
  task automatic walk_byte(input logic [7:0] b, input logic eof);
    logic [31:0] w;
    bit          emit;
    step_results.delete();
    if (!done) begin
      case (ph)
        PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_TYPE, PH_CHUNK_ID, PH_CHUNK_LEN: begin
          shift_word = {b, shift_word[31:8]};
          word_bytes = word_bytes + 2'd1;
          if (word_bytes == 2'd0) begin
            w = shift_word;
            case (ph)
              PH_RIFF_ID: begin
                if (w != FOURCC_RIFF) give_failure();
                else ph = PH_RIFF_SIZE;
              end
              PH_RIFF_SIZE: ph = PH_WAVE_TYPE;
              PH_WAVE_TYPE: begin
                if (w != FOURCC_WAVE) give_failure();
                else ph = PH_CHUNK_ID;
              end
              PH_CHUNK_ID: begin
                cur_id = w;
                ph = PH_CHUNK_LEN;
              end
              default: begin
                remaining = w;
                ph = (w == 32'd0) ? PH_CHUNK_ID : PH_PAYLOAD;
                if (cur_id == FOURCC_DATA && !data_seen) begin
                  data_seen = 1'b1;
                  data_off = position + 32'd1;
                  data_len = w;
                end
                // an empty fmt chunk counts once its length is known
                if (cur_id == FOURCC_FMT && !fmt_seen && w == 32'd0) fmt_seen = 1'b1;
                check_complete();
              end
            endcase
          end
        end
        PH_PAYLOAD: begin
          emit = (cur_id == FOURCC_FMT) && !fmt_seen;
          if (emit) add_result(KIND_FORMAT, b, 32'd0, 32'd0);
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            ph = PH_CHUNK_ID;
            if (emit) fmt_seen = 1'b1;
            check_complete();
          end
        end
        default: ;
      endcase
      position = position + 32'd1;
    end
    if (eof) begin
      if (!done) give_failure();
      clear_parser();
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) results_due.push_back(step_results[i]);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Accept requests into the model and check results against it.
  always @(posedge clk) begin
    parse_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (rst) begin
      req_taken <= 1'b0;
      clear_parser();
      results_due.delete();
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) walk_byte(file_byte, end_of_file);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d", kind);
          error_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("format_byte", 32'(want.fmt), 32'(format_byte));
          check_field("audio_offset", want.off, audio_offset);
          check_field("audio_length", want.len, audio_length);
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Request driver
  always @(negedge clk) begin
    file_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_requests.size() > 0 &&
                   !(byte_requests[0].drain && results_due.size() > 0)) begin
        req = byte_requests.pop_front();
        file_byte <= req.data;
        end_of_file <= req.eof;
        in_valid <= 1'b1;
        send_gap = calm ? 0 : pause_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && !calm && $urandom_range(0, 3) == 0) hold_left = pause_len();
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Move the built file into the request queue, marking its last byte.
  task automatic queue_file(input bit drain);
    file_req_t req;
    foreach (file_bytes[i]) begin
      req.data = file_bytes[i];
      req.eof = (i == file_bytes.size() - 1);
      req.drain = drain && (i == 0);
      byte_requests.push_back(req);
    end
    file_bytes.delete();
  endtask

  task automatic build_file();
    int unsigned r;
    int unsigned sel;
    int unsigned cut;
    logic [31:0] id;
    logic [31:0] len;
    bit          open_end;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_random($urandom_range(1, 16));
    end else if (r < 14) begin
      // one flipped bit in the RIFF id or in the WAVE type
      push_word(FOURCC_RIFF ^ ((r < 10) ? (32'd1 << $urandom_range(0, 31)) : 32'd0));
      push_word($urandom);
      push_word(FOURCC_WAVE ^ ((r >= 10) ? (32'd1 << $urandom_range(0, 31)) : 32'd0));
      push_random($urandom_range(0, 4));
    end else begin
      push_word(FOURCC_RIFF);
      push_word($urandom);
      push_word(FOURCC_WAVE);
      open_end = 1'b0;
      for (int c = $urandom_range(2, 5); c > 0 && !open_end; c--) begin
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          id = $urandom_range(0, 1) ? $urandom
                                    : (($urandom_range(0, 1) ? FOURCC_FMT : FOURCC_DATA) ^
                                       (32'd1 << $urandom_range(0, 31)));
          len = $urandom_range(0, 6);
        end else if (sel < 6) begin
          id = FOURCC_FMT;
          r = $urandom_range(0, 9);
          len = (r < 3) ? 32'd16 : (r < 5) ? 32'd0 : $urandom_range(1, 8);
        end else begin
          id = FOURCC_DATA;
          len = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10);
        end
        push_word(id);
        push_word(len);
        // skip only the start of a huge payload; nothing past it is reachable
        if (len > 40) begin
          open_end = 1'b1;
          push_random($urandom_range(0, 6));
        end else begin
          push_random(len);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else begin
        push_random($urandom_range(0, 3));
      end
    end
    if (file_bytes.size() == 0) push_random(1);
  endtask

  initial begin
    bit first;
    // bad RIFF id, end of file on its last byte
    push_word(FOURCC_RIFF ^ 32'h0100_0000);
    queue_file(1'b0);
    // end of file on the very first byte
    file_bytes.push_back(8'hFF);
    queue_file(1'b0);
    // bad WAVE type with extreme size bytes
    push_word(FOURCC_RIFF);
    push_word(32'hFFFF_0000);
    push_word(FOURCC_WAVE ^ 32'h8000_0000);
    queue_file(1'b0);
    first = 1'b1;
    while (byte_requests.size() < BYTE_TARGET) begin
      build_file();
      queue_file(first || $urandom_range(0, 11) == 0);
      first = 1'b0;
    end

    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_requests.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $error("no request or result moved for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
